### rtl/core/longest_nonincreasing_subsequence_top_defines.svh
// Assertion macros for the longest non-increasing subsequence RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef LONGEST_NONINCREASING_SUBSEQUENCE_TOP_DEFINES_SVH
`define LONGEST_NONINCREASING_SUBSEQUENCE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LNIS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lnis: same-cycle check failed");

// Next-cycle implication.
`define LNIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lnis: next-cycle check failed");

// Invariant that holds at every edge.
`define LNIS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("lnis: invariant failed");

`endif

### rtl/core/lnis_pkg.sv
// Package for the longest non-increasing subsequence block.
// Holds field widths, request/result structs and the cell status type; no dependencies.
package lnis_pkg;

  localparam int unsigned ValueBits     = 31;
  localparam int unsigned LenBits       = 9;
  localparam int unsigned MaxLengthDflt = 256;

  typedef logic [ValueBits-1:0] value_t;

  typedef struct packed {
    logic [ValueBits-1:0] sample_value;
    logic                 start_sequence;
  } lnis_req_t;

  typedef struct packed {
    logic [LenBits-1:0] best_length;
    logic               table_overflow;
  } lnis_rsp_t;

  typedef struct packed {
    logic lt;          // effective tail is below the incoming value
    logic took_empty;  // this cell is the chosen slot and was empty
  } lnis_cell_stat_t;

endpackage

### rtl/core/lnis_cell.sv
// One slot of the tail table: holds a tail value and picks itself when it is
// the first slot below the incoming value. Depends on lnis_pkg.
module lnis_cell
  import lnis_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            start_i,
  input  value_t          value_i,
  input  logic            prev_lt_i,
  output lnis_cell_stat_t stat_o
);

  value_t tail_q, tail_d;
  value_t tail_eff;
  logic   lt;
  logic   pick;

  // A start request sees the slot as already cleared.
  assign tail_eff = start_i ? '0 : tail_q;
  assign lt       = (tail_eff < value_i);
  assign pick     = lt && !prev_lt_i;

  assign stat_o.lt         = lt;
  assign stat_o.took_empty = pick && (tail_eff == '0);

  always_comb begin
    tail_d = tail_q;
    if (en_i) begin
      if (pick) begin
        tail_d = value_i;
      end else if (start_i) begin
        tail_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= '0;
    end else begin
      tail_q <= tail_d;
    end
  end

endmodule

### rtl/core/longest_nonincreasing_subsequence_top.sv
// Channel | Signals                                  | Direction
// --------+------------------------------------------+----------
// request | in_valid_i, in_ready_o, in_req_i         | in
// result  | out_valid_o, out_ready_i, out_rsp_o      | out
//
// One request per cycle: every cell compares its tail against the broadcast
// value in parallel and hands its compare flag to its right neighbor, so the
// first slot below the value picks itself in the accept cycle.
// The result sits in an output register from the cycle after the request is taken.
// A stalled result holds in_ready_o low; a new request enters as the old result
// leaves. Reset empties every slot at once and clears the length; no sweep.
// Depends on lnis_pkg, lnis_cell and the assertion macro header.
`include "longest_nonincreasing_subsequence_top_defines.svh"

module longest_nonincreasing_subsequence_top
  import lnis_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MaxLengthDflt
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lnis_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lnis_rsp_t out_rsp_o
);

  // Length counter must hold MAX_LENGTH itself and at least the port width.
  localparam int unsigned CntW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned LenW = (CntW > LenBits) ? CntW : LenBits;

  logic                  in_fire;
  logic                  start;
  value_t                value;
  lnis_cell_stat_t       stat  [MAX_LENGTH];
  logic [MAX_LENGTH-1:0] lt_vec;
  logic [MAX_LENGTH-1:0] took_empty_vec;
  logic                  grow;
  logic                  overflow;

  logic [LenW-1:0] len_q, len_d;
  logic            out_valid_q, out_valid_d;
  lnis_rsp_t       rsp_q, rsp_d;

  // Take a new request whenever the result register is free or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign start      = in_req_i.start_sequence;
  assign value      = in_req_i.sample_value;

  // Row of cells; slot 0 sees no neighbor below the value.
  for (genvar k = 0; k < MAX_LENGTH; k++) begin : g_cell
    logic prev_lt;
    if (k == 0) begin : g_head
      assign prev_lt = 1'b0;
    end else begin : g_link
      assign prev_lt = stat[k-1].lt;
    end

    lnis_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (in_fire),
      .start_i  (start),
      .value_i  (value),
      .prev_lt_i(prev_lt),
      .stat_o   (stat[k])
    );

    assign lt_vec[k]         = stat[k].lt;
    assign took_empty_vec[k] = stat[k].took_empty;
  end

  // Grow when the chosen slot was empty; overflow when no slot is below a
  // nonzero value (a zero value fits nowhere and is simply dropped).
  assign grow     = |took_empty_vec;
  assign overflow = (value != '0) && !lt_vec[MAX_LENGTH-1];

  always_comb begin
    len_d = len_q;
    if (in_fire) begin
      len_d = (start ? '0 : len_q) + LenW'(grow);
    end
  end

  always_comb begin
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q;
    if (in_fire) begin
      rsp_d.best_length    = len_d[LenBits-1:0];
      rsp_d.table_overflow = overflow;
      out_valid_d          = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset; out_valid_q qualifies it.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // At most one slot may claim the empty position.
  `LNIS_ASSERT_ALWAYS(a_one_empty_pick, $onehot0(took_empty_vec))
  // Overflow only happens with the table completely full.
  `LNIS_ASSERT_SAME(a_ovf_full, in_fire && overflow && !start, len_q == LenW'(MAX_LENGTH))
  // A fresh sequence with a real value has length one.
  `LNIS_ASSERT_NEXT(a_start_len, in_fire && start && (value != '0), len_q == LenW'(1))
  // Length never exceeds the table size.
  `LNIS_ASSERT_ALWAYS(a_len_bound, len_q <= LenW'(MAX_LENGTH))

endmodule
